/* hw/rtl/assert_macros.svh */
// Assertion macros used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clock edge outside of reset.
`define MMU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every rising clock edge, reset included.
`define MMU_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hw/rtl/mmu_pkg.sv */
// Shared types and constants of the matrix multiply unit
package mmu_pkg;

  localparam int MAX_DIM_DEF = 4;

  typedef enum logic [1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_COMPUTE = 2'd2
  } mmu_op_e;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic data_vld;
    logic clear;
  } mmu_mac_ctl_t;

endpackage

/* hw/rtl/mmu_store.sv */
// Matrix element store: one write port, one read port, registered read data
module mmu_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/mmu_mac.sv */
// Multiply-accumulate unit with round-toward-zero and saturation to Q16.16
module mmu_mac #(
  parameter int MAX_DIM = mmu_pkg::MAX_DIM_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic signed [31:0]   a_i,
  input  logic signed [31:0]   b_i,
  input  mmu_pkg::mmu_mac_ctl_t ctl_i,
  output logic                 busy_o,
  output logic signed [31:0]   result_o
);
  import mmu_pkg::*;

  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int ACC_W = 64 + DW;
  localparam int QW    = ACC_W - 16;

  logic signed [63:0]    mul_q;
  logic                  mul_vld_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] acc_adj;
  logic signed [QW-1:0]  quo;
  logic [QW-32:0]        quo_hi;
  logic                  fits;

  always_ff @(posedge clk_i) begin
    mul_q <= a_i * b_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else begin
      mul_vld_q <= ctl_i.data_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.clear) begin
      acc_q <= '0;
    end else if (mul_vld_q) begin
      acc_q <= acc_q + ACC_W'(mul_q);
    end
  end

  // Bias negative sums so the arithmetic shift truncates toward zero
  always_comb begin
    acc_adj  = acc_q + (acc_q[ACC_W-1] ? ACC_W'(16'hFFFF) : '0);
    quo      = QW'(acc_adj >>> 16);
    quo_hi   = quo[QW-1:31];
    fits     = (&quo_hi) || !(|quo_hi);
    if (fits) begin
      result_o = quo[31:0];
    end else if (quo[QW-1]) begin
      result_o = 32'sh8000_0000;
    end else begin
      result_o = 32'sh7FFF_FFFF;
    end
  end

  assign busy_o = mul_vld_q;

endmodule

/* hw/rtl/matrix_multiply_unit.sv */
// Top level of the matrix multiply unit: sequencer, element stores and MAC.
// Load transactions (write A, write B) are accepted back to back while the block is idle.
// A compute transaction (rows and cols nonzero) stalls the input until its last element is loaded: per
// element one store read per inner step, then a drain that waits for the MAC to empty and the output
// register to be free (only the drain when inner is zero).
// Reset sets all three dimensions to their maximum; store contents stay undefined.
`include "assert_macros.svh"

module matrix_multiply_unit #(
  parameter int MAX_DIM = mmu_pkg::MAX_DIM_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [2:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic [3:0]         element_index_i,
  input  logic signed [31:0] element_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] product_value_o,
  output logic [1:0]         product_row_o,
  output logic [1:0]         product_col_o,
  output logic               last_o
);
  import mmu_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int PW    = 2 * DW;

  localparam logic [1:0] CFG_A_ROWS     = 2'd0;
  localparam logic [1:0] CFG_INNER_SIZE = 2'd1;
  localparam logic [1:0] CFG_B_COLS     = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_e;

  state_e         state_q;
  logic [DW-1:0]  rows_q, inner_q, cols_q;
  logic [DW-1:0]  cfg_dim;
  logic [DW-1:0]  i_q, j_q, k_q;
  logic           rd_vld_q;
  logic           out_valid_q;
  logic signed [31:0] out_value_q;
  logic [1:0]     out_row_q, out_col_q;
  logic           out_last_q;

  logic           in_acc;
  logic           wr_ok, wr_a, wr_b;
  logic [AW-1:0]  waddr;
  logic [PW-1:0]  a_lin, b_lin;
  logic           rd_en;
  logic [31:0]    a_data, b_data;
  logic           mac_busy;
  logic signed [31:0] mac_result;
  mmu_mac_ctl_t   mac_ctl;
  logic           k_last, col_last, row_last, el_last;
  logic           pipe_busy, out_free, out_load;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign wr_ok = (32'(element_index_i) < DEPTH);
  assign wr_a  = in_acc && (operation_i == OP_WRITE_A) && wr_ok;
  assign wr_b  = in_acc && (operation_i == OP_WRITE_B) && wr_ok;
  assign waddr = AW'(element_index_i);

  // Row-major strides with the dimensions in force at compute time
  assign a_lin = PW'(i_q) * PW'(inner_q) + PW'(k_q);
  assign b_lin = PW'(k_q) * PW'(cols_q) + PW'(j_q);
  assign rd_en = (state_q == S_RUN);

  mmu_store #(.DEPTH(DEPTH), .AW(AW)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (wr_a),
    .waddr_i (waddr),
    .wdata_i (element_value_i),
    .re_i    (rd_en),
    .raddr_i (AW'(a_lin)),
    .rdata_o (a_data)
  );

  mmu_store #(.DEPTH(DEPTH), .AW(AW)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (wr_b),
    .waddr_i (waddr),
    .wdata_i (element_value_i),
    .re_i    (rd_en),
    .raddr_i (AW'(b_lin)),
    .rdata_o (b_data)
  );

  assign k_last    = (k_q == inner_q - DW'(1));
  assign col_last  = (j_q == cols_q - DW'(1));
  assign row_last  = (i_q == rows_q - DW'(1));
  assign el_last   = col_last && row_last;
  assign pipe_busy = rd_vld_q || mac_busy;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign out_load  = (state_q == S_DRAIN) && !pipe_busy && out_free;

  // Keep the accumulator clear between elements and while idle
  assign mac_ctl.data_vld = rd_vld_q;
  assign mac_ctl.clear    = (state_q == S_IDLE) || out_load;

  mmu_mac #(.MAX_DIM(MAX_DIM)) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .a_i      ($signed(a_data)),
    .b_i      ($signed(b_data)),
    .ctl_i    (mac_ctl),
    .busy_o   (mac_busy),
    .result_o (mac_result)
  );

  // Clamp each dimension to MAX_DIM on write
  assign cfg_dim = (32'(cfg_wdata_i) > MAX_DIM) ? DW'(MAX_DIM) : DW'(cfg_wdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= DW'(MAX_DIM);
      inner_q <= DW'(MAX_DIM);
      cols_q  <= DW'(MAX_DIM);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_A_ROWS:     rows_q  <= cfg_dim;
        CFG_INNER_SIZE: inner_q <= cfg_dim;
        CFG_B_COLS:     cols_q  <= cfg_dim;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc && (operation_i == OP_COMPUTE) && (rows_q != '0) && (cols_q != '0)) begin
            i_q     <= '0;
            j_q     <= '0;
            k_q     <= '0;
            state_q <= (inner_q == '0) ? S_DRAIN : S_RUN;
          end
        end
        S_RUN: begin
          if (k_last) begin
            k_q     <= '0;
            state_q <= S_DRAIN;
          end else begin
            k_q <= k_q + DW'(1);
          end
        end
        S_DRAIN: begin
          if (out_load) begin
            out_value_q <= mac_result;
            out_row_q   <= 2'(i_q);
            out_col_q   <= 2'(j_q);
            out_last_q  <= el_last;
            if (el_last) begin
              state_q <= S_IDLE;
            end else begin
              if (col_last) begin
                j_q <= '0;
                i_q <= i_q + DW'(1);
              end else begin
                j_q <= j_q + DW'(1);
              end
              state_q <= (inner_q == '0) ? S_DRAIN : S_RUN;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign product_value_o = out_value_q;
  assign product_row_o   = out_row_q;
  assign product_col_o   = out_col_q;
  assign last_o          = out_last_q;

  `MMU_ASSERT(a_no_write_in_compute, (state_q != S_IDLE) |-> (!wr_a && !wr_b), "store write during compute")
  `MMU_ASSERT(a_load_on_empty_pipe, out_load |-> (!rd_vld_q && !mac_busy), "result taken before MAC drained")
  `MMU_ASSERT(a_accept_on_empty_pipe, !in_stall_o |-> (!rd_vld_q && !mac_busy), "accepting with MAC busy")
  `MMU_ASSERT_ALWAYS(a_read_only_in_run, rd_vld_q |-> !wr_a && !wr_b, "read overlaps a store write")

endmodule

/* bench/mmu_tb_pkg.sv */
// Register indexes and reserved operation code shared by the matrix multiply testbench files
`timescale 1ns / 1ps

package mmu_tb_pkg;

  typedef enum logic [1:0] {
    REG_A_ROWS     = 2'd0,
    REG_INNER_SIZE = 2'd1,
    REG_B_COLS     = 2'd2,
    REG_SPARE      = 2'd3
  } mmu_reg_e;

  localparam logic [1:0] OP_RESERVED = 2'd3;

endpackage

/* bench/matrix_multiply_unit_checker.sv */
// Scoreboard of the matrix multiply unit: predicts every product element and checks the output
`timescale 1ns / 1ps

module matrix_multiply_unit_checker
  import mmu_pkg::*;
  import mmu_tb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [2:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         operation_i,
  input  logic [3:0]         element_index_i,
  input  logic signed [31:0] element_value_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] product_value_i,
  input  logic [1:0]         product_row_i,
  input  logic [1:0]         product_col_i,
  input  logic               last_i,
  output int                 error_count_o,
  output int                 pending_o
);

  localparam int DIM       = MAX_DIM_DEF;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         row;
    logic [1:0]         col;
    logic               last;
  } product_t;

  product_t           product_q[$];
  logic signed [31:0] store_a [DIM*DIM];
  logic signed [31:0] store_b [DIM*DIM];
  logic [2:0]         rows_cfg, inner_cfg, cols_cfg;

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    logic signed [66:0] acc;
    logic [66:0]        mag;
    product_t           got, want;
    int                 rows, inner, cols, r, c, k;

    if (!rst_ni) begin
      rows_cfg      = 3'd4;
      inner_cfg     = 3'd4;
      cols_cfg      = 3'd4;
      error_count_o = 0;
      product_q.delete();
      for (k = 0; k < DIM*DIM; k++) begin
        store_a[k] = '0;
        store_b[k] = '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_A_ROWS:     rows_cfg  = cfg_wdata_i;
          REG_INNER_SIZE: inner_cfg = cfg_wdata_i;
          REG_B_COLS:     cols_cfg  = cfg_wdata_i;
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        if (operation_i == OP_WRITE_A) begin
          store_a[element_index_i] = element_value_i;
        end else if (operation_i == OP_WRITE_B) begin
          store_b[element_index_i] = element_value_i;
        end else if (operation_i == OP_COMPUTE) begin
          rows  = (rows_cfg > DIM) ? DIM : rows_cfg;
          inner = (inner_cfg > DIM) ? DIM : inner_cfg;
          cols  = (cols_cfg > DIM) ? DIM : cols_cfg;
          for (r = 0; r < rows; r++) begin
            for (c = 0; c < cols; c++) begin
              acc = '0;
              for (k = 0; k < inner; k++)
                acc = acc + store_a[r*inner + k] * store_b[k*cols + c];
              // Q32.32 back to Q16.16: truncate the magnitude, then saturate
              mag = acc[66] ? 67'(-acc) : 67'(acc);
              mag = mag >> 16;
              if (acc[66])
                want.value = (mag >= 67'h80000000) ? 32'sh80000000 : 32'(0 - mag[31:0]);
              else
                want.value = (mag > 67'h7FFFFFFF) ? 32'sh7FFFFFFF : mag[31:0];
              want.row  = r[1:0];
              want.col  = c[1:0];
              want.last = (r == rows - 1) && (c == cols - 1);
              product_q.push_back(want);
            end
          end
        end
      end

      if (out_valid_i && !out_stall_i) begin
        got = '{product_value_i, product_row_i, product_col_i, last_i};
        if (product_q.size() == 0) begin
          error_count_o++;
          if (error_count_o <= MAX_SHOWN)
            $display("%0t: unexpected product row %0d col %0d value %h last %0d", $realtime,
                     got.row, got.col, got.value, got.last);
        end else begin
          want = product_q.pop_front();
          if (got !== want) begin
            error_count_o++;
            if (error_count_o <= MAX_SHOWN)
              $display("%0t: product mismatch: expected row %0d col %0d value %h last %0d, got row %0d col %0d value %h last %0d",
                       $realtime, want.row, want.col, want.value, want.last,
                       got.row, got.col, got.value, got.last);
          end
        end
      end
    end
    pending_o = product_q.size();
  end

endmodule

/* bench/matrix_multiply_unit_tb.sv */
// Testbench top of the matrix multiply unit: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module matrix_multiply_unit_tb;
  import mmu_pkg::*;
  import mmu_tb_pkg::*;

  localparam int DIM          = MAX_DIM_DEF;
  localparam int DRAIN_CYCLES = 40;
  localparam int SUB_ITEMS    = 20;
  localparam int IDLE_PCT  [4] = '{0, 77, 0, 33};
  localparam int STALL_PCT [4] = '{0, 0, 77, 33};

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_we_i        = 1'b0;
  logic [1:0]         cfg_index_i     = '0;
  logic [2:0]         cfg_wdata_i     = '0;
  logic               in_valid_i      = 1'b0;
  logic [1:0]         operation_i     = '0;
  logic [3:0]         element_index_i = '0;
  logic signed [31:0] element_value_i = '0;
  logic               out_stall_i     = 1'b0;
  logic               in_stall_o, out_valid_o, last_o;
  logic signed [31:0] product_value_o;
  logic [1:0]         product_row_o, product_col_o;

  int error_count, pending;
  int idle_pct  = 0;
  int stall_pct = 0;
  int need_a, need_b, items_sent;
  bit written_a [DIM*DIM];
  bit written_b [DIM*DIM];

  matrix_multiply_unit uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .operation_i, .element_index_i, .element_value_i,
    .out_valid_o, .out_stall_i, .product_value_o, .product_row_o, .product_col_o, .last_o
  );

  matrix_multiply_unit_checker product_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .operation_i, .element_index_i, .element_value_i,
    .out_valid_i(out_valid_o), .out_stall_i, .product_value_i(product_value_o),
    .product_row_i(product_row_o), .product_col_i(product_col_o), .last_i(last_o),
    .error_count_o(error_count), .pending_o(pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [31:0] random_value();
    case ($urandom_range(5))
      0, 1:    return $urandom;
      2, 3:    return 32'($urandom_range(32'h100000)) - 32'h80000;    // about +-8.0
      4:       return 32'($urandom_range(32'h4000000)) - 32'h2000000; // about +-512.0
      default: begin
        case ($urandom_range(4))
          0:       return 32'h7FFFFFFF;
          1:       return 32'h80000000;
          2:       return 32'hFFFFFFFF;
          3:       return 32'h00010000;
          default: return 32'h0;
        endcase
      end
    endcase
  endfunction

  function automatic logic [2:0] random_dim();
    case ($urandom_range(9))
      0:       return 3'd0;
      1:       return 3'($urandom_range(7, 5));
      default: return 3'($urandom_range(4, 1));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input logic [1:0] op, input logic [3:0] idx, input logic [31:0] val);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    element_index_i <= idx;
    element_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    if (op == OP_WRITE_A) written_a[idx] = 1'b1;
    if (op == OP_WRITE_B) written_b[idx] = 1'b1;
    items_sent++;
  endtask

  // Drain the block, then program all dimension registers.
  task automatic set_dims(input logic [2:0] rows, input logic [2:0] inner, input logic [2:0] cols);
    int r, i, c;
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_A_ROWS;
    cfg_wdata_i <= rows;
    @(negedge clk_i);
    cfg_index_i <= REG_INNER_SIZE;
    cfg_wdata_i <= inner;
    @(negedge clk_i);
    cfg_index_i <= REG_B_COLS;
    cfg_wdata_i <= cols;
    @(negedge clk_i);
    // the spare index must leave the dimensions alone
    cfg_index_i <= REG_SPARE;
    cfg_wdata_i <= 3'($urandom);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    r = (rows > DIM) ? DIM : rows;
    i = (inner > DIM) ? DIM : inner;
    c = (cols > DIM) ? DIM : cols;
    need_a = (r == 0 || c == 0) ? 0 : r * i;
    need_b = (r == 0 || c == 0) ? 0 : i * c;
  endtask

  initial begin
    int  phase, sub, start, n;
    bit  ready;
    logic [2:0] rd, id, cd;

    items_sent = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: saturation both ways, truncation toward zero, reserved op, degenerate sizes
    set_dims(3'd1, 3'd2, 3'd1);
    send_item(OP_WRITE_A, 4'd0, 32'h7FFFFFFF);
    send_item(OP_WRITE_A, 4'd1, 32'h7FFFFFFF);
    send_item(OP_WRITE_B, 4'd0, 32'h7FFFFFFF);
    send_item(OP_WRITE_B, 4'd1, 32'h7FFFFFFF);
    send_item(OP_COMPUTE, 4'd0, 32'h0);
    send_item(OP_WRITE_A, 4'd0, 32'h80000000);
    send_item(OP_WRITE_A, 4'd1, 32'h80000000);
    send_item(OP_COMPUTE, 4'hF, 32'hFFFFFFFF);
    send_item(OP_WRITE_A, 4'd0, 32'hFFFFFFFF);
    send_item(OP_WRITE_B, 4'd0, 32'h00000001);
    send_item(OP_WRITE_A, 4'd1, 32'h0);
    send_item(OP_COMPUTE, 4'h5, 32'h5A5A5A5A);
    send_item(OP_RESERVED, 4'hA, 32'hA5A5A5A5);
    send_item(OP_WRITE_A, 4'hF, 32'h12345678);
    send_item(OP_WRITE_B, 4'hF, 32'hEDCBA987);
    send_item(OP_COMPUTE, 4'h0, 32'h0);
    set_dims(3'd1, 3'd0, 3'd1);
    send_item(OP_COMPUTE, 4'h0, 32'h0);
    set_dims(3'd0, 3'd3, 3'd2);
    send_item(OP_COMPUTE, 4'h0, 32'h0);
    set_dims(3'd7, 3'd0, 3'd6);
    send_item(OP_COMPUTE, 4'h0, 32'h0);

    for (phase = 0; phase < 4; phase++) begin
      idle_pct  = IDLE_PCT[phase];
      stall_pct = STALL_PCT[phase];
      for (sub = 0; sub < 3; sub++) begin
        if (sub == 0 && phase == 0) begin
          rd = 3'd4; id = 3'd4; cd = 3'd4;
        end else if (sub == 0 && phase == 1) begin
          rd = 3'd1; id = 3'd1; cd = 3'd1;
        end else if (sub == 0 && phase == 3) begin
          rd = 3'd7; id = 3'd7; cd = 3'd7;
        end else begin
          rd = random_dim(); id = random_dim(); cd = random_dim();
        end
        set_dims(rd, id, cd);
        start = items_sent;
        while (items_sent - start < SUB_ITEMS) begin
          if ($urandom_range(99) < 70) begin
            // well-formed: load the operands (fresh or partly reused), then compute
            for (n = 0; n < need_a; n++)
              if (!written_a[n] || $urandom_range(1)) send_item(OP_WRITE_A, 4'(n), random_value());
            for (n = 0; n < need_b; n++)
              if (!written_b[n] || $urandom_range(1)) send_item(OP_WRITE_B, 4'(n), random_value());
            send_item(OP_COMPUTE, 4'($urandom), $urandom);
          end else begin
            case ($urandom_range(2))
              0: send_item(OP_RESERVED, 4'($urandom), $urandom);
              1: send_item($urandom_range(1) ? OP_WRITE_A : OP_WRITE_B, 4'($urandom),
                           random_value());
              default: begin
                ready = 1'b1;
                for (n = 0; n < need_a; n++) ready &= written_a[n];
                for (n = 0; n < need_b; n++) ready &= written_b[n];
                // never read an entry that was not loaded
                if (ready) send_item(OP_COMPUTE, 4'($urandom), $urandom);
                else send_item(OP_WRITE_B, 4'($urandom), random_value());
              end
            endcase
          end
        end
      end
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
